// ===== rtl/klc_pkg.sv =====
// Shared types and constants for the keyed LRU entry cache.
package klc_pkg;

  localparam int unsigned KEY_W       = 64;
  localparam int unsigned STAMP_W     = 64;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned DEF_ENTRIES = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } klc_state_e;

  // Write strobes for the slot store; both share one write address.
  typedef struct packed {
    logic key_we;
    logic stamp_we;
  } klc_wr_t;

endpackage

// ===== rtl/klc_store.sv =====
// Slot store: key and last-used memories, one write and one registered read port.
module klc_store #(
  parameter int unsigned Entries = klc_pkg::DEF_ENTRIES
) (
  input  logic                          clk_i,
  input  klc_pkg::klc_wr_t              wr_i,
  input  logic [$clog2(Entries)-1:0]    wr_addr_i,
  input  logic [klc_pkg::KEY_W-1:0]     wr_key_i,
  input  logic [klc_pkg::STAMP_W-1:0]   wr_stamp_i,
  input  logic [$clog2(Entries)-1:0]    rd_addr_i,
  output logic [klc_pkg::KEY_W-1:0]     rd_key_o,
  output logic [klc_pkg::STAMP_W-1:0]   rd_stamp_o
);
  import klc_pkg::*;

  logic [KEY_W-1:0]   key_mem   [Entries];
  logic [STAMP_W-1:0] stamp_mem [Entries];

  always_ff @(posedge clk_i) begin
    if (wr_i.key_we) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    rd_key_o <= key_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.stamp_we) begin
      stamp_mem[wr_addr_i] <= wr_stamp_i;
    end
    rd_stamp_o <= stamp_mem[rd_addr_i];
  end

endmodule

// ===== rtl/keyed_lru_entry_cache.sv =====
// Top level of the keyed LRU entry cache: scan controller, LRU tracking, result register.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one lookup item: a 64-bit key
//   and the current frame stamp. Output channel (out_valid_o/out_ready_i)
//   returns exactly one result item per lookup: hit flag, slot index, and the
//   evicted key when a full cache replaces its least recently used slot.
//   One item is scanned at a time. After acceptance the controller walks
//   every filled slot through the store's read port, one slot per cycle, and
//   compares key and last-used stamp as the data returns. The result is
//   registered once every filled slot (at most ENTRIES) has been compared and
//   the output register is free. The next item is accepted only after that
//   write-back, so a new item is not taken before the last one is through.
//   The single read port of the slot store sets the scan rate.
//   Reset empties the cache by clearing the fill count; the memories are not
//   swept, since only slots below the fill count are ever compared.
//   When the receiver stalls, the finished result holds in the output register
//   and the next item is still accepted and scanned; its write-back and result
//   wait until the held result is taken.
module keyed_lru_entry_cache #(
  parameter int unsigned ENTRIES = klc_pkg::DEF_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [klc_pkg::KEY_W-1:0]     lookup_key_i,
  input  logic [klc_pkg::STAMP_W-1:0]   frame_stamp_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [klc_pkg::SLOT_W-1:0]    slot_index_o,
  output logic                          evicted_o,
  output logic [klc_pkg::KEY_W-1:0]     evicted_key_o
);
  import klc_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  klc_state_e state_q, state_d;

  // Request capture
  logic [KEY_W-1:0]   key_q;
  logic [STAMP_W-1:0] stamp_q;

  // Fill count and scan counters
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] issue_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;

  // Match and LRU tracking
  logic               hit_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic [STAMP_W-1:0] best_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic [KEY_W-1:0]   best_key_q;

  // Result register
  logic               out_valid_q;
  logic               res_hit_q;
  logic [IDX_W-1:0]   res_slot_q;
  logic               res_ev_q;
  logic [KEY_W-1:0]   res_evk_q;

  // Store port
  klc_wr_t            wr;
  logic [IDX_W-1:0]   wr_addr;
  logic [KEY_W-1:0]   rd_key;
  logic [STAMP_W-1:0] rd_stamp;

  logic in_acc;
  logic scan_end;
  logic full;
  logic done_go;
  logic [31:0] slot_ext;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign scan_end   = (issue_q == cnt_q) && !cmp_vld_q;
  assign full       = (cnt_q == CNT_W'(ENTRIES));
  // Write back and load the result only once the output register is free.
  assign done_go    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SCAN;
      ST_SCAN: if (scan_end) state_d = ST_DONE;
      ST_DONE: if (done_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Pick the write-back target: hit slot, next free slot, or the LRU victim.
  always_comb begin
    wr      = '0;
    wr_addr = best_idx_q;
    if (done_go) begin
      if (hit_q) begin
        wr.stamp_we = 1'b1;
        wr_addr     = hit_idx_q;
      end else if (!full) begin
        wr.key_we   = 1'b1;
        wr.stamp_we = 1'b1;
        wr_addr     = cnt_q[IDX_W-1:0];
      end else begin
        wr.key_we   = 1'b1;
        wr.stamp_we = 1'b1;
        wr_addr     = best_idx_q;
      end
    end
  end

  klc_store #(
    .Entries (ENTRIES)
  ) u_store (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .wr_addr_i  (wr_addr),
    .wr_key_i   (key_q),
    .wr_stamp_i (stamp_q),
    .rd_addr_i  (issue_q[IDX_W-1:0]),
    .rd_key_o   (rd_key),
    .rd_stamp_o (rd_stamp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control: fill count, scan issue, read-data valid, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      issue_q     <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Read data is valid in the cycle after a slot read is issued.
      cmp_vld_q <= (state_q == ST_SCAN) && (issue_q != cnt_q);
      if (in_acc) begin
        issue_q <= '0;
        hit_q   <= 1'b0;
      end
      // Issue one slot read per cycle until every filled slot is covered.
      if (state_q == ST_SCAN && issue_q != cnt_q) begin
        issue_q <= issue_q + CNT_W'(1);
      end
      if (cmp_vld_q && !hit_q && rd_key == key_q) begin
        hit_q <= 1'b1;
      end
      if (done_go && !hit_q && !full) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (done_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath: capture, compare tracking, result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q   <= lookup_key_i;
      stamp_q <= frame_stamp_i;
    end
    cmp_idx_q <= issue_q[IDX_W-1:0];
    if (cmp_vld_q) begin
      // Keep the first matching slot only.
      if (!hit_q && rd_key == key_q) begin
        hit_idx_q <= cmp_idx_q;
      end
      // Strictly smaller stamp wins, so ties keep the lowest index.
      if (cmp_idx_q == '0 || rd_stamp < best_q) begin
        best_q     <= rd_stamp;
        best_idx_q <= cmp_idx_q;
        best_key_q <= rd_key;
      end
    end
    if (done_go) begin
      res_hit_q  <= hit_q;
      res_ev_q   <= !hit_q && full;
      res_evk_q  <= (!hit_q && full) ? best_key_q : '0;
      res_slot_q <= wr_addr;
    end
  end

  assign slot_ext      = 32'(res_slot_q);
  assign out_valid_o   = out_valid_q;
  assign hit_o         = res_hit_q;
  assign slot_index_o  = slot_ext[SLOT_W-1:0];
  assign evicted_o     = res_ev_q;
  assign evicted_key_o = res_evk_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(ENTRIES))
    else $error("fill count above capacity");

  a_cmp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> state_q == ST_SCAN)
    else $error("read data returned outside scan");

  a_hit_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_q && state_q == ST_DONE) |-> CNT_W'(hit_idx_q) < cnt_q)
    else $error("hit slot beyond fill count");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_go && !hit_q && !full) |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("fill count did not advance on miss");

  a_scan_done_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && state_d == ST_DONE) |-> issue_q == cnt_q)
    else $error("scan ended before covering filled slots");
`endif

endmodule
